// ----- rtl/wsfd_pkg.sv -----
package wsfd_pkg;

   // Parser phase of the receive byte stream.
   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   // Kind of a result word.
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } out_kind_type;

   // Error codes.
   localparam logic ERR_TOO_LONG    = 1'b0;
   localparam logic ERR_CONTROL_LEN = 1'b1;

   // Header length codes and limits.
   localparam logic [6:0]  LEN7_MAX      = 7'd125;
   localparam logic [6:0]  LEN_16BIT     = 7'd126;
   localparam logic [6:0]  LEN_64BIT     = 7'd127;
   localparam logic [31:0] MAX_LEN_RESET = 32'd8388608;
   localparam logic [3:0]  OPCODE_TEXT   = 4'h1;

   // Extended length and key byte counts.
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// ----- rtl/websocket_frame_deframer_core.sv -----
// Throughput: one byte per cycle while the result register is not stalled;
// the header and payload parser is combinational, between the input register and
// the result register, which captures each result word that a byte emits.
// Reset (synchronous, active high) clears the parser to expect a first header
// byte, clears the message state and error halt, and loads the maximum length.
module websocket_frame_deframer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wsfd_pkg::out_kind_type rsp_out_kind,
   output logic [3:0]            rsp_opcode,
   output logic                  rsp_final_flag,
   output logic                  rsp_control_flag,
   output logic                  rsp_text_message,
   output logic [31:0]           rsp_payload_length,
   output logic                  rsp_masked_flag,
   output logic [31:0]           rsp_mask_key,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_frame_end,
   output logic                  rsp_message_end,
   output logic                  rsp_error_code,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data
);
   import wsfd_pkg::*;

   // Configuration and input stage.
   logic [31:0] max_len_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        advance;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  hdr_first_ff, hdr_first_in;
   logic [7:0]  hdr_second_ff, hdr_second_in;
   logic [31:0] len_ff, len_in;
   logic        len_hi_ff, len_hi_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] remain_ff, remain_in;
   logic        in_msg_ff, in_msg_in;
   logic        msg_text_ff, msg_text_in;
   logic        halted_ff, halted_in;

   // Result word being formed.
   logic         emit;
   out_kind_type emit_kind;
   logic [7:0]   emit_data;
   logic         emit_fend;
   logic         emit_mend;
   logic         emit_err;
   logic         emit_text;
   logic         after_len;
   logic         hdr_done;
   logic         is_ctl;

   // Result register.
   logic         out_valid_ff;
   out_kind_type out_kind_ff;
   logic [3:0]   out_opcode_ff;
   logic         out_final_ff;
   logic         out_control_ff;
   logic         out_text_ff;
   logic [31:0]  out_len_ff;
   logic         out_masked_ff;
   logic [31:0]  out_key_ff;
   logic [7:0]   out_data_ff;
   logic         out_fend_ff;
   logic         out_mend_ff;
   logic         out_err_ff;

   // The pipe moves when the result register is empty or being drained.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   // Parser next state and result word.
   always_comb begin
      phase_in      = phase_ff;
      hdr_first_in  = hdr_first_ff;
      hdr_second_in = hdr_second_ff;
      len_in        = len_ff;
      len_hi_in     = len_hi_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      remain_in     = remain_ff;
      in_msg_in     = in_msg_ff;
      msg_text_in   = msg_text_ff;
      halted_in     = halted_ff;
      emit          = 1'b0;
      emit_kind     = KIND_HEADER;
      emit_data     = 8'd0;
      emit_fend     = 1'b0;
      emit_mend     = 1'b0;
      emit_err      = ERR_TOO_LONG;
      emit_text     = msg_text_ff;
      after_len     = 1'b0;
      hdr_done      = 1'b0;
      is_ctl        = hdr_first_ff[3];

      if (!halted_ff) begin
         case (phase_ff)
            PH_SECOND: begin
               hdr_second_in = in_byte_ff;
               key_in        = 32'd0;
               len_in        = 32'd0;
               len_hi_in     = 1'b0;
               if (in_byte_ff[6:0] == LEN_16BIT) begin
                  count_in = EXT16_BYTES;
                  phase_in = PH_EXTLEN;
               end else if (in_byte_ff[6:0] == LEN_64BIT) begin
                  count_in = EXT64_BYTES;
                  phase_in = PH_EXTLEN;
               end else begin
                  len_in    = {25'd0, in_byte_ff[6:0]};
                  after_len = 1'b1;
               end
            end
            PH_EXTLEN: begin
               // Keep the low 32 bits and a sticky flag for any higher bit.
               len_in    = {len_ff[23:0], in_byte_ff};
               len_hi_in = len_hi_ff || (len_ff[31:24] != 8'd0);
               count_in  = count_ff - 4'd1;
               after_len = (count_in == 4'd0);
            end
            PH_KEY: begin
               key_in   = {key_ff[23:0], in_byte_ff};
               count_in = count_ff - 4'd1;
               hdr_done = (count_in == 4'd0);
            end
            PH_PAYLOAD: begin
               remain_in = remain_ff - 32'd1;
               emit      = 1'b1;
               emit_kind = KIND_PAYLOAD;
               emit_data = in_byte_ff;
               emit_fend = (remain_in == 32'd0);
               emit_mend = emit_fend && !is_ctl && hdr_first_ff[7];
               if (emit_fend) begin
                  phase_in = PH_FIRST;
                  if (emit_mend) begin
                     in_msg_in   = 1'b0;
                     msg_text_in = 1'b0;
                  end
               end
            end
            default: begin
               hdr_first_in = in_byte_ff;
               phase_in     = PH_SECOND;
            end
         endcase

         // A masked frame still needs its key.
         if (after_len) begin
            if (hdr_second_in[7]) begin
               count_in = KEY_BYTES;
               phase_in = PH_KEY;
            end else begin
               hdr_done = 1'b1;
            end
         end

         // Header complete: check lengths, then open the message.
         if (hdr_done) begin
            emit = 1'b1;
            if (len_hi_in || (len_in > max_len_ff)) begin
               halted_in = 1'b1;
               emit_kind = KIND_ERROR;
               emit_err  = ERR_TOO_LONG;
            end else if (is_ctl && (len_in > {25'd0, LEN7_MAX})) begin
               halted_in = 1'b1;
               emit_kind = KIND_ERROR;
               emit_err  = ERR_CONTROL_LEN;
            end else begin
               if (!is_ctl && !in_msg_ff) begin
                  in_msg_in   = 1'b1;
                  msg_text_in = (hdr_first_ff[3:0] == OPCODE_TEXT);
               end
               emit_text = msg_text_in;
               remain_in = len_in;
               emit_kind = KIND_HEADER;
               if (len_in == 32'd0) begin
                  emit_fend = 1'b1;
                  emit_mend = !is_ctl && hdr_first_ff[7];
                  phase_in  = PH_FIRST;
                  if (emit_mend) begin
                     in_msg_in   = 1'b0;
                     msg_text_in = 1'b0;
                  end
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
      end
   end

   // Control registers: configuration, input valid, parser state, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_LEN_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_FIRST;
         hdr_first_ff  <= 8'd0;
         hdr_second_ff <= 8'd0;
         len_ff        <= 32'd0;
         len_hi_ff     <= 1'b0;
         count_ff      <= 4'd0;
         key_ff        <= 32'd0;
         remain_ff     <= 32'd0;
         in_msg_ff     <= 1'b0;
         msg_text_ff   <= 1'b0;
         halted_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff && emit;
         end
         if (advance && in_valid_ff) begin
            phase_ff      <= phase_in;
            hdr_first_ff  <= hdr_first_in;
            hdr_second_ff <= hdr_second_in;
            len_ff        <= len_in;
            len_hi_ff     <= len_hi_in;
            count_ff      <= count_in;
            key_ff        <= key_in;
            remain_ff     <= remain_in;
            in_msg_ff     <= in_msg_in;
            msg_text_ff   <= msg_text_in;
            halted_ff     <= halted_in;
         end
      end
   end

   // Payload registers of the input and result stages.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && in_valid_ff && emit) begin
         out_kind_ff    <= emit_kind;
         out_opcode_ff  <= hdr_first_in[3:0];
         out_final_ff   <= hdr_first_in[7];
         out_control_ff <= hdr_first_in[3];
         out_text_ff    <= emit_text;
         out_len_ff     <= len_hi_in ? 32'hFFFF_FFFF : len_in;
         out_masked_ff  <= hdr_second_in[7];
         out_key_ff     <= key_in;
         out_data_ff    <= emit_data;
         out_fend_ff    <= emit_fend;
         out_mend_ff    <= emit_mend;
         out_err_ff     <= emit_err;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_kind       = out_kind_ff;
   assign rsp_opcode         = out_opcode_ff;
   assign rsp_final_flag     = out_final_ff;
   assign rsp_control_flag   = out_control_ff;
   assign rsp_text_message   = out_text_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_masked_flag    = out_masked_ff;
   assign rsp_mask_key       = out_key_ff;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_frame_end      = out_fend_ff;
   assign rsp_message_end    = out_mend_ff;
   assign rsp_error_code     = out_err_ff;

endmodule
